// ===== rtl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg: shared types and constants for the delimited command deframer
// Configuration register indexes, reset values, field widths and the
// character codes used by the case fold.
// ----------------------------------------------------------------------------
package dcd_pkg;

    // default geometry
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MSG_LEN_DEF     = 20;

    // result field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int QUEUE_W = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD    = 3'd4;

    // register reset values
    localparam logic [BYTE_W-1:0] START_A_RST = 8'd91;  // '['
    localparam logic [BYTE_W-1:0] START_B_RST = 8'd33;  // '!'
    localparam logic [BYTE_W-1:0] STOP_A_RST  = 8'd93;  // ']'
    localparam logic [BYTE_W-1:0] STOP_B_RST  = 8'h0D;  // CR

    // case fold: bytes strictly between these bounds are upper-case letters
    localparam logic [BYTE_W-1:0] UPPER_LO   = 8'd64;
    localparam logic [BYTE_W-1:0] UPPER_HI   = 8'd91;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'd32;

    // op codes of an input request
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start_a;
        logic [BYTE_W-1:0] start_b;
        logic [BYTE_W-1:0] stop_a;
        logic [BYTE_W-1:0] stop_b;
        logic              fold;
    } t_cfg;

endpackage

// ===== rtl/dcd_ram.sv =====
// ----------------------------------------------------------------------------
// dcd_ram: generic simple dual-port RAM
// One write port, one read port with a registered read and a read enable.
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dcd_framer.sv =====
// ----------------------------------------------------------------------------
// dcd_framer: frame collection and queue push
// Folds case, detects start and stop characters, writes collected bytes
// straight into the free queue slot and records the frame length on push.
// ----------------------------------------------------------------------------
module dcd_framer
    import dcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MSG_LEN     = MSG_LEN_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH),
    localparam int FW = $clog2(MSG_LEN + 1),
    localparam int AW = $clog2(QUEUE_DEPTH * MSG_LEN)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_req,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_cfg              i_cfg,
    input  logic [CW-1:0]     i_count,
    output logic              o_store_we,
    output logic [AW-1:0]     o_store_waddr,
    output logic [BYTE_W-1:0] o_store_wdata,
    output logic              o_len_we,
    output logic [CW-1:0]     o_len_waddr,
    output logic [FW-1:0]     o_len_wdata,
    output logic [CW-1:0]     o_write_slot
);

    logic          r_collecting, n_collecting;
    logic [FW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_write_slot, n_write_slot;

    logic [BYTE_W-1:0] folded;
    logic              is_start;
    logic              is_stop;
    logic              queue_full;
    logic              has_room;

    // case fold and character match
    always_comb begin
        folded = i_rx_byte;
        if (i_cfg.fold && (i_rx_byte > UPPER_LO) && (i_rx_byte < UPPER_HI)) begin
            folded = i_rx_byte + CASE_DELTA;
        end
    end

    assign is_start   = (folded == i_cfg.start_a) || (folded == i_cfg.start_b);
    assign is_stop    = (folded == i_cfg.stop_a) || (folded == i_cfg.stop_b);
    assign queue_full = (i_count == CW'(QUEUE_DEPTH - 1));
    assign has_room   = (r_fill < FW'(MSG_LEN));

    // frame state update; start wins over stop
    always_comb begin
        n_collecting = r_collecting;
        n_fill       = r_fill;
        n_write_slot = r_write_slot;
        o_store_we   = 1'b0;
        o_len_we     = 1'b0;
        if (i_byte_req) begin
            priority if (is_start) begin
                n_collecting = 1'b1;
                n_fill       = '0;
            end else if (r_collecting && is_stop) begin
                n_collecting = 1'b0;
                if (!queue_full) begin
                    o_len_we     = 1'b1;
                    n_write_slot = (r_write_slot == CW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_write_slot + 1'b1;
                end
            end else if (r_collecting && has_room) begin
                o_store_we = 1'b1;
                n_fill     = r_fill + 1'b1;
            end else begin
                // idle, or buffer full: byte dropped
            end
        end
    end

    // the free slot is never read, so bytes go there directly
    assign o_store_waddr = AW'(r_write_slot) * AW'(MSG_LEN) + AW'(r_fill);
    assign o_store_wdata = folded;
    assign o_len_waddr   = r_write_slot;
    assign o_len_wdata   = r_fill;
    assign o_write_slot  = r_write_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_fill       <= '0;
            r_write_slot <= '0;
        end else begin
            r_collecting <= n_collecting;
            r_fill       <= n_fill;
            r_write_slot <= n_write_slot;
        end
    end

endmodule

// ===== rtl/dcd_reader.sv =====
// ----------------------------------------------------------------------------
// dcd_reader: message read sequencer
// Walks the oldest slot one byte per cycle through the store RAM, pads past
// the stored length with zeros and holds the RAM output while stalled.
// ----------------------------------------------------------------------------
module dcd_reader
    import dcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MSG_LEN     = MSG_LEN_DEF,
    localparam int CW = $clog2(QUEUE_DEPTH),
    localparam int FW = $clog2(MSG_LEN + 1),
    localparam int KW = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1,
    localparam int AW = $clog2(QUEUE_DEPTH * MSG_LEN)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_read_req,
    input  logic [CW-1:0]      i_count,
    input  logic               i_stall,
    output logic               o_store_re,
    output logic [AW-1:0]      o_store_raddr,
    input  logic [BYTE_W-1:0]  i_store_rdata,
    output logic [CW-1:0]      o_read_slot,
    input  logic [FW-1:0]      i_len_rdata,
    output logic               o_valid,
    output logic               o_msg_valid,
    output logic [BYTE_W-1:0]  o_msg_byte,
    output logic [POS_W-1:0]   o_byte_pos,
    output logic               o_last,
    output logic [QUEUE_W-1:0] o_queued
);

    logic          r_pend, n_pend;
    logic          r_empty, n_empty;
    logic [KW-1:0] r_k, n_k;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_read_slot, n_read_slot;

    logic              consume;
    logic              is_last;
    logic [AW-1:0]     base;
    logic [KW+POS_W-1:0]   pos_wide;
    logic [CW+QUEUE_W-1:0] cnt_wide;

    assign consume = r_pend && !i_stall;
    assign is_last = r_empty || (r_k == KW'(MSG_LEN - 1));
    assign base    = AW'(r_read_slot) * AW'(MSG_LEN);

    // sequencer: one store read per delivered byte
    always_comb begin
        n_pend      = r_pend;
        n_empty     = r_empty;
        n_k         = r_k;
        n_n         = r_n;
        n_read_slot = r_read_slot;
        o_store_re  = 1'b0;
        priority if (i_read_req) begin
            n_pend     = 1'b1;
            n_empty    = (i_count == '0);
            n_n        = i_count;
            n_k        = '0;
            o_store_re = (i_count != '0);
        end else if (consume && is_last) begin
            n_pend = 1'b0;
            if (!r_empty) begin
                n_read_slot = (r_read_slot == CW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_read_slot + 1'b1;
            end
        end else if (consume) begin
            n_k        = r_k + 1'b1;
            o_store_re = 1'b1;
        end else begin
            // idle or stalled: hold
        end
    end

    assign o_store_raddr = base + AW'(n_k);
    assign o_read_slot   = r_read_slot;

    // result fields
    assign pos_wide    = {{POS_W{1'b0}}, r_k};
    assign cnt_wide    = {{QUEUE_W{1'b0}}, r_n};
    assign o_valid     = r_pend;
    assign o_msg_valid = !r_empty;
    assign o_msg_byte  = (!r_empty && (FW'(r_k) < i_len_rdata)) ? i_store_rdata : '0;
    assign o_byte_pos  = pos_wide[POS_W-1:0];
    assign o_last      = is_last;
    assign o_queued    = cnt_wide[QUEUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_empty     <= 1'b0;
            r_k         <= '0;
            r_n         <= '0;
            r_read_slot <= '0;
        end else begin
            r_pend      <= n_pend;
            r_empty     <= n_empty;
            r_k         <= n_k;
            r_n         <= n_n;
            r_read_slot <= n_read_slot;
        end
    end

endmodule

// ===== rtl/delimited_command_deframer.sv =====
// ----------------------------------------------------------------------------
// delimited_command_deframer: delimited frame receiver with message queue
// Collects start/stop delimited frames from a byte stream into a circular
// queue held in RAM and delivers the oldest message byte by byte on request.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_op, i_rx_byte
//   out     | output    | o_out_valid / i_out_stall | o_msg_valid, o_msg_byte,
//           |           |                           | o_byte_pos, o_last, o_queued
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// A read request starts with the first store RAM read, then delivers
// MSG_LEN results (one for an empty queue); the input stalls until its
// last result is taken. Output stalls freeze the RAM read.
// Reset is synchronous; no clearing pass, the store is masked by stored length.
// ----------------------------------------------------------------------------
module delimited_command_deframer
    import dcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MSG_LEN     = MSG_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_msg_valid,
    output logic [BYTE_W-1:0]     o_msg_byte,
    output logic [POS_W-1:0]      o_byte_pos,
    output logic                  o_last,
    output logic [QUEUE_W-1:0]    o_queued,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(MSG_LEN + 1);
    localparam int AW = $clog2(QUEUE_DEPTH * MSG_LEN);

    t_cfg r_cfg;

    logic          in_accept;
    logic          byte_req;
    logic          read_req;
    logic [CW-1:0] write_slot;
    logic [CW-1:0] read_slot;
    logic [CW-1:0] count;

    logic              store_we;
    logic [AW-1:0]     store_waddr;
    logic [BYTE_W-1:0] store_wdata;
    logic              store_re;
    logic [AW-1:0]     store_raddr;
    logic [BYTE_W-1:0] store_rdata;
    logic              len_we;
    logic [CW-1:0]     len_waddr;
    logic [FW-1:0]     len_wdata;
    logic [FW-1:0]     len_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_a <= START_A_RST;
            r_cfg.start_b <= START_B_RST;
            r_cfg.stop_a  <= STOP_A_RST;
            r_cfg.stop_b  <= STOP_B_RST;
            r_cfg.fold    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_A: r_cfg.start_a <= i_cfg_wdata;
                CFG_START_B: r_cfg.start_b <= i_cfg_wdata;
                CFG_STOP_A:  r_cfg.stop_a  <= i_cfg_wdata;
                CFG_STOP_B:  r_cfg.stop_b  <= i_cfg_wdata;
                CFG_FOLD:    r_cfg.fold    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input handshake: one request at a time while a read is delivered
    assign o_in_stall = o_out_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign byte_req   = in_accept && (i_op == OP_BYTE);
    assign read_req   = in_accept && (i_op == OP_READ);

    // queue occupancy, modulo the slot count
    assign count = (write_slot >= read_slot) ? (write_slot - read_slot)
                                             : (write_slot - read_slot + CW'(QUEUE_DEPTH));

    dcd_framer #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_LEN     (MSG_LEN)
    ) u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_req    (byte_req),
        .i_rx_byte     (i_rx_byte),
        .i_cfg         (r_cfg),
        .i_count       (count),
        .o_store_we    (store_we),
        .o_store_waddr (store_waddr),
        .o_store_wdata (store_wdata),
        .o_len_we      (len_we),
        .o_len_waddr   (len_waddr),
        .o_len_wdata   (len_wdata),
        .o_write_slot  (write_slot)
    );

    dcd_reader #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_LEN     (MSG_LEN)
    ) u_reader (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_read_req    (read_req),
        .i_count       (count),
        .i_stall       (i_out_stall),
        .o_store_re    (store_re),
        .o_store_raddr (store_raddr),
        .i_store_rdata (store_rdata),
        .o_read_slot   (read_slot),
        .i_len_rdata   (len_rdata),
        .o_valid       (o_out_valid),
        .o_msg_valid   (o_msg_valid),
        .o_msg_byte    (o_msg_byte),
        .o_byte_pos    (o_byte_pos),
        .o_last        (o_last),
        .o_queued      (o_queued)
    );

    // message bytes, one row of MSG_LEN per slot
    dcd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH * MSG_LEN)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // collected length per slot; bytes past it read as zero
    dcd_ram #(
        .WIDTH (FW),
        .DEPTH (QUEUE_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (1'b1),
        .i_raddr (read_slot),
        .o_rdata (len_rdata)
    );

    // slot pointers stay inside the queue
    a_slots_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (write_slot < CW'(QUEUE_DEPTH - 1) || write_slot == CW'(QUEUE_DEPTH - 1)) &&
        (read_slot < CW'(QUEUE_DEPTH - 1) || read_slot == CW'(QUEUE_DEPTH - 1)))
        else $error("slot pointer out of range");

    // the last byte of a message taken pops exactly one slot
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last && o_msg_valid) |=>
        (read_slot == (($past(read_slot) == CW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : $past(read_slot) + 1'b1)))
        else $error("read slot not advanced after last byte");

    // no push while a read is delivered
    a_no_push_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |=> $stable(write_slot))
        else $error("write slot moved during a read");

    // an empty result only when the queue was empty
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_msg_valid) |-> (o_last && o_queued == '0 && count == '0))
        else $error("empty result with messages queued");

endmodule
